// ===== rtl/threshold_move_to_front_cache_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the threshold move-to-front cache
// Short forms of same-cycle and next-cycle implications on clock and reset.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_MOVE_TO_FRONT_CACHE_CORE_ASSERT_SVH
`define THRESHOLD_MOVE_TO_FRONT_CACHE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TMTFC_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tmtfc check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define TMTFC_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tmtfc check failed in the next cycle");

`endif

// ===== rtl/tmtfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtfc_pkg
// Widths, limits, register indexes and cell control type for the cache.
// ----------------------------------------------------------------------------
package tmtfc_pkg;

   localparam int CAPACITY      = 16;
   localparam int KEY_BITS      = 64;
   localparam int COUNT_BITS    = 16;
   localparam int THR_BITS      = 16;
   localparam int IDX_BITS      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CAP_BITS      = 5;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(CAPACITY);
   localparam logic [CAP_BITS-1:0]   CAP_FULL  = CAP_BITS'(CAPACITY);
   localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(3);

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = CSR_IDX_BITS'(1);

   // per-cell control from the sequencer
   typedef struct packed {
      logic look;    // compare the held key this cycle
      logic valid;   // cell lies below the fill level
      logic shift;   // take the neighbour's entry
      logic load;    // take the request key at the front
      logic cnt_wr;  // rewrite the count of the matching cell
   } cell_ctl_type;

endpackage

// ===== rtl/tmtfc_cell.sv =====
// ----------------------------------------------------------------------------
// tmtfc_cell
// One buffer slot: holds a key and its hit count, compares against the
// request key and hands its entry on to the next slot when shifting.
// ----------------------------------------------------------------------------
module tmtfc_cell (
   input  logic                                clock,
   input  tmtfc_pkg::cell_ctl_type             ctl,
   input  logic [tmtfc_pkg::KEY_BITS-1:0]      req_key,
   input  logic [tmtfc_pkg::COUNT_BITS-1:0]    new_count,
   input  logic [tmtfc_pkg::KEY_BITS-1:0]      prev_key,
   input  logic [tmtfc_pkg::COUNT_BITS-1:0]    prev_count,
   output logic [tmtfc_pkg::KEY_BITS-1:0]      key_q,
   output logic [tmtfc_pkg::COUNT_BITS-1:0]    count_q,
   output logic                                match_q,
   output logic [tmtfc_pkg::COUNT_BITS-1:0]    match_count
);

   logic [tmtfc_pkg::KEY_BITS-1:0]   key_ff;
   logic [tmtfc_pkg::COUNT_BITS-1:0] count_ff;
   logic                             match_ff;

   // capture the compare result during lookup
   always_ff @(posedge clock) begin
      if (ctl.look) begin
         match_ff <= ctl.valid && (key_ff == req_key);
      end
   end

   // shift from the neighbour, load at the front, or bump the count
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         key_ff   <= prev_key;
         count_ff <= prev_count;
      end else if (ctl.load) begin
         key_ff   <= req_key;
         count_ff <= new_count;
      end else if (ctl.cnt_wr && match_ff) begin
         count_ff <= new_count;
      end
   end

   assign key_q       = key_ff;
   assign count_q     = count_ff;
   assign match_q     = match_ff;
   assign match_count = match_ff ? count_ff : '0;

endmodule

// ===== rtl/threshold_move_to_front_cache_core.sv =====
// ----------------------------------------------------------------------------
// threshold_move_to_front_cache_core
// Move-to-front key buffer with a promotion threshold on the hit count,
// built as a row of slot cells that compare in parallel and shift as one.
// ----------------------------------------------------------------------------
// Sequence: each accepted request passes a lookup state, then an update state.
// A new request is taken in the update cycle of the one before, once that update
//    commits, so the cell row compare and the row shift set the pace.
// A held response does not block the next request until its update is due.
// Reset: synchronous; buffer empty, capacity 16, threshold 3. No clear pass.
module threshold_move_to_front_cache_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [63:0]                            req_key,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic [15:0]                            rsp_count_after,
   output logic                                   rsp_promoted,
   output logic                                   rsp_evicted,
   output logic [63:0]                            rsp_evicted_key,
   output logic [15:0]                            rsp_evicted_count,
   output logic [4:0]                             rsp_occupancy,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tmtfc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [tmtfc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOK   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [tmtfc_pkg::KEY_BITS-1:0]   key_ff;
   logic [tmtfc_pkg::CAP_BITS-1:0]   fill_ff, fill_in;
   logic [tmtfc_pkg::CAP_BITS-1:0]   cap_ff;
   logic [tmtfc_pkg::THR_BITS-1:0]   thr_ff;

   logic                             rsp_valid_ff;
   logic                             hit_ff, promoted_ff, evicted_ff;
   logic [tmtfc_pkg::COUNT_BITS-1:0] count_after_ff, evicted_count_ff;
   logic [tmtfc_pkg::KEY_BITS-1:0]   evicted_key_ff;
   logic [tmtfc_pkg::CAP_BITS-1:0]   occupancy_ff;

   logic [tmtfc_pkg::KEY_BITS-1:0]   cell_key    [tmtfc_pkg::CAPACITY];
   logic [tmtfc_pkg::COUNT_BITS-1:0] cell_count  [tmtfc_pkg::CAPACITY];
   logic [tmtfc_pkg::COUNT_BITS-1:0] cell_mcount [tmtfc_pkg::CAPACITY];
   logic [tmtfc_pkg::CAPACITY-1:0]   cell_match;
   tmtfc_pkg::cell_ctl_type          cell_ctl    [tmtfc_pkg::CAPACITY];

   logic                             accept_w, commit_w;
   logic                             hit_w, promote_w, evict_w, load_front_w, cnt_wr_w;
   logic [tmtfc_pkg::COUNT_BITS-1:0] cnt_old_w, cnt_new_w, new_count_w;
   logic [tmtfc_pkg::IDX_BITS-1:0]   pos_w;
   logic [tmtfc_pkg::CAP_BITS-1:0]   cap_w, keep_w, limit_w, ev_idx_w;

   // handshakes
   assign commit_w  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == ST_IDLE) || commit_w);
   assign accept_w  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // sequence lookup then update
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_w) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit_w) state_in = accept_w ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the request key for the lookup and update cycles
   always_ff @(posedge clock) begin
      if (accept_w) begin
         key_ff <= req_key;
      end
   end

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= tmtfc_pkg::CAP_RESET;
         thr_ff <= tmtfc_pkg::THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tmtfc_pkg::CSR_CAPACITY:  cap_ff <= csr_wdata[tmtfc_pkg::CAP_BITS-1:0];
            tmtfc_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata[tmtfc_pkg::THR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // gather the matching slot and its count
   always_comb begin
      cnt_old_w = '0;
      pos_w     = '0;
      for (int i = 0; i < tmtfc_pkg::CAPACITY; i++) begin
         cnt_old_w = cnt_old_w | cell_mcount[i];
         if (cell_match[i]) pos_w = tmtfc_pkg::IDX_BITS'(i);
      end
   end

   // decide the update
   always_comb begin
      hit_w     = |cell_match;
      cnt_new_w = (cnt_old_w == tmtfc_pkg::COUNT_MAX) ? cnt_old_w
                                                      : cnt_old_w + 1'b1;
      promote_w = hit_w && (cnt_old_w == thr_ff) && (pos_w != '0);

      if (cap_ff == '0) begin
         cap_w = tmtfc_pkg::CAP_BITS'(1);
      end else if (cap_ff > tmtfc_pkg::CAP_FULL) begin
         cap_w = tmtfc_pkg::CAP_FULL;
      end else begin
         cap_w = cap_ff;
      end

      evict_w  = !hit_w && (fill_ff >= cap_w);
      keep_w   = evict_w ? cap_w - 1'b1 : fill_ff;
      ev_idx_w = fill_ff - 1'b1;

      if (!hit_w) begin
         limit_w = keep_w;
      end else if (promote_w) begin
         limit_w = tmtfc_pkg::CAP_BITS'(pos_w);
      end else begin
         limit_w = '0;
      end

      load_front_w = promote_w || !hit_w;
      cnt_wr_w     = hit_w && !promote_w;
      new_count_w  = hit_w ? cnt_new_w : tmtfc_pkg::COUNT_BITS'(1);
      fill_in      = hit_w ? fill_ff : keep_w + 1'b1;
   end

   // drive the cell row
   always_comb begin
      for (int i = 0; i < tmtfc_pkg::CAPACITY; i++) begin
         cell_ctl[i].look   = (state_ff == ST_LOOK);
         cell_ctl[i].valid  = tmtfc_pkg::CAP_BITS'(i) < fill_ff;
         cell_ctl[i].shift  = commit_w && (i != 0) && (tmtfc_pkg::CAP_BITS'(i) <= limit_w);
         cell_ctl[i].load   = commit_w && (i == 0) && load_front_w;
         cell_ctl[i].cnt_wr = commit_w && cnt_wr_w;
      end
   end

   for (genvar g = 0; g < tmtfc_pkg::CAPACITY; g++) begin : g_cell
      logic [tmtfc_pkg::KEY_BITS-1:0]   prev_key;
      logic [tmtfc_pkg::COUNT_BITS-1:0] prev_count;

      if (g == 0) begin : g_front
         assign prev_key   = '0;
         assign prev_count = '0;
      end else begin : g_chain
         assign prev_key   = cell_key[g-1];
         assign prev_count = cell_count[g-1];
      end

      tmtfc_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[g]),
         .req_key     (key_ff),
         .new_count   (new_count_w),
         .prev_key    (prev_key),
         .prev_count  (prev_count),
         .key_q       (cell_key[g]),
         .count_q     (cell_count[g]),
         .match_q     (cell_match[g]),
         .match_count (cell_mcount[g])
      );
   end

   // advance the fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (commit_w) begin
         fill_ff <= fill_in;
      end
   end

   // hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_w) begin
         hit_ff           <= hit_w;
         count_after_ff   <= new_count_w;
         promoted_ff      <= promote_w;
         evicted_ff       <= evict_w;
         evicted_key_ff   <= evict_w ? cell_key[ev_idx_w[tmtfc_pkg::IDX_BITS-1:0]] : '0;
         evicted_count_ff <= evict_w ? cell_count[ev_idx_w[tmtfc_pkg::IDX_BITS-1:0]] : '0;
         occupancy_ff     <= fill_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_count_after   = count_after_ff;
   assign rsp_promoted      = promoted_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_evicted_key   = evicted_key_ff;
   assign rsp_evicted_count = evicted_count_ff;
   assign rsp_occupancy     = occupancy_ff;

endmodule

// ===== rtl/tmtfc_checker.sv =====
// ----------------------------------------------------------------------------
// tmtfc_checker
// Port-level checks on the cache core, attached by bind.
// ----------------------------------------------------------------------------
`include "threshold_move_to_front_cache_core_assert.svh"

module tmtfc_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_hit,
   input  logic [15:0]                            rsp_count_after,
   input  logic                                   rsp_promoted,
   input  logic                                   rsp_evicted,
   input  logic [63:0]                            rsp_evicted_key,
   input  logic [15:0]                            rsp_evicted_count,
   input  logic [4:0]                             rsp_occupancy
);

   logic hit_clean, miss_clean;

   // fields a hit must show: nothing evicted, buffer non-empty
   assign hit_clean = !rsp_evicted && (rsp_evicted_key == 64'd0)
                      && (rsp_evicted_count == 16'd0) && (rsp_occupancy != 5'd0);

   // fields a miss must show: count one, no promotion, occupancy in range
   assign miss_clean = (rsp_count_after == 16'd1) && !rsp_promoted
                       && (rsp_occupancy != 5'd0)
                       && (rsp_occupancy <= tmtfc_pkg::CAP_FULL);

   // a stalled response stays offered
   `TMTFC_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // a request is followed by its lookup cycle, during which no request enters
   `TMTFC_CHECK_NEXT(a_req_gap, req_valid && !req_stall, req_stall)

   // a hit never evicts and leaves the buffer non-empty
   `TMTFC_CHECK_NOW(a_hit_fields, rsp_valid && rsp_hit, hit_clean)

   // a miss inserts with count one and keeps occupancy in range
   `TMTFC_CHECK_NOW(a_miss_fields, rsp_valid && !rsp_hit, miss_clean)

endmodule

bind threshold_move_to_front_cache_core tmtfc_checker u_tmtfc_checker (.*);

// ===== sim/threshold_move_to_front_cache_core_tb.sv =====
// ----------------------------------------------------------------------------
// threshold_move_to_front_cache_core_tb
// Drives key lookups into the move-to-front cache and predicts each response
// from a private copy of the key list, hit counts and registers. Covers
// promotion, eviction and capacity limits under random idling on both
// channels.
// ----------------------------------------------------------------------------
module threshold_move_to_front_cache_core_tb;

   typedef struct packed {
      logic        hit;
      logic [15:0] count_after;
      logic        promoted;
      logic        evicted;
      logic [63:0] evicted_key;
      logic [15:0] evicted_count;
      logic [4:0]  occupancy;
   } lookup_outcome_type;

   // Tracks the key list and holds the outcomes still owed by the block
   class lookup_tracker_type;
      logic [63:0]        keys [tmtfc_pkg::CAPACITY];
      logic [15:0]        counts [tmtfc_pkg::CAPACITY];
      int                 fill;
      logic [4:0]         cap_reg;
      logic [15:0]        thr_reg;
      lookup_outcome_type owed [$];
      int                 mismatches;

      function new();
         fill       = 0;
         cap_reg    = 5'd16;
         thr_reg    = 16'd3;
         mismatches = 0;
      endfunction

      function void note_register(logic [tmtfc_pkg::CSR_IDX_BITS-1:0] idx,
                                  logic [tmtfc_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == tmtfc_pkg::CSR_CAPACITY) begin
            cap_reg = data[4:0];
         end else if (idx == tmtfc_pkg::CSR_THRESHOLD) begin
            thr_reg = data[15:0];
         end
      endfunction

      // Work out the outcome of one lookup and advance the key list
      function void predict_lookup(logic [63:0] key);
         int                 cap;
         int                 pos;
         int                 keep;
         bit                 found;
         bit                 match;
         logic [15:0]        c;
         lookup_outcome_type r;
         r     = '0;
         found = 0;
         pos   = 0;
         cap   = (cap_reg == 0) ? 1 : ((cap_reg > tmtfc_pkg::CAPACITY) ?
                                       tmtfc_pkg::CAPACITY : int'(cap_reg));
         for (int i = 0; i < fill; i++) begin
            if (!found && keys[i] == key) begin
               found = 1;
               pos   = i;
            end
         end
         if (found) begin
            c     = counts[pos];
            match = (c == thr_reg);
            if (c != 16'hFFFF) c++;
            counts[pos]   = c;
            r.hit         = 1'b1;
            r.count_after = c;
            // promote to the front only from a later slot
            if (match && pos > 0) begin
               for (int i = pos; i > 0; i--) begin
                  keys[i]   = keys[i-1];
                  counts[i] = counts[i-1];
               end
               keys[0]    = key;
               counts[0]  = c;
               r.promoted = 1'b1;
            end
         end else begin
            keep = fill;
            // drop the rear, and anything beyond a lowered capacity
            if (fill >= cap) begin
               r.evicted       = 1'b1;
               r.evicted_key   = keys[fill-1];
               r.evicted_count = counts[fill-1];
               keep            = cap - 1;
            end
            for (int i = keep; i > 0; i--) begin
               keys[i]   = keys[i-1];
               counts[i] = counts[i-1];
            end
            keys[0]       = key;
            counts[0]     = 16'd1;
            fill          = keep + 1;
            r.count_after = 16'd1;
         end
         r.occupancy = 5'(fill);
         owed.push_back(r);
      endfunction

      function void flag(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(lookup_outcome_type got);
         lookup_outcome_type want;
         if (owed.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = owed.pop_front();
            flag("hit", 64'(want.hit), 64'(got.hit));
            flag("count_after", 64'(want.count_after), 64'(got.count_after));
            flag("promoted", 64'(want.promoted), 64'(got.promoted));
            flag("evicted", 64'(want.evicted), 64'(got.evicted));
            flag("evicted_key", want.evicted_key, got.evicted_key);
            flag("evicted_count", 64'(want.evicted_count), 64'(got.evicted_count));
            flag("occupancy", 64'(want.occupancy), 64'(got.occupancy));
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [63:0]                         req_key;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_hit;
   logic [15:0]                         rsp_count_after;
   logic                                rsp_promoted;
   logic                                rsp_evicted;
   logic [63:0]                         rsp_evicted_key;
   logic [15:0]                         rsp_evicted_count;
   logic [4:0]                          rsp_occupancy;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [tmtfc_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [tmtfc_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   lookup_tracker_type lookups = new();
   bit                 quiet   = 1'b0;
   logic [63:0]        key_pool [32];

   threshold_move_to_front_cache_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_count_after   (rsp_count_after),
      .rsp_promoted      (rsp_promoted),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_occupancy     (rsp_occupancy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response channel in short random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(1, 4) - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         lookups.check_response({rsp_hit, rsp_count_after, rsp_promoted, rsp_evicted,
                                 rsp_evicted_key, rsp_evicted_count, rsp_occupancy});
      end
   end

   // Present one key, with a random hold-off before it
   task automatic send_request(logic [63:0] key);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap       = $urandom_range(1, 4);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_key   = key;
      do @(posedge clock); while (req_stall);
      lookups.predict_lookup(key);
   endtask

   task automatic write_register(logic [tmtfc_pkg::CSR_IDX_BITS-1:0] idx,
                                 logic [tmtfc_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      lookups.note_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hold requests until every response is in, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (lookups.outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_key(int span);
      if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
      return key_pool[$urandom_range(0, span - 1)];
   endfunction

   initial begin
      logic [63:0]  next_key;
      logic [4:0]   cap;
      logic [15:0]  thr;
      int           span;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_key   = '0;
      csr_valid = 1'b0;
      csr_index = tmtfc_pkg::CSR_CAPACITY;
      csr_wdata = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: promotion from a later slot and at the front, reset registers
      send_request(64'h0);
      send_request('1);
      repeat (4) send_request(64'h0);
      repeat (3) send_request('1);
      repeat (4) send_request(64'h5A5A_A5A5_0F0F_F0F0);
      settle();

      // Capacity of one: lowered below fill, then a single entry swaps out
      write_register(tmtfc_pkg::CSR_THRESHOLD, 16'd1);
      write_register(tmtfc_pkg::CSR_CAPACITY, 16'd1);
      send_request(64'h1111_2222_3333_4444);
      send_request(64'h1111_2222_3333_4444);
      send_request(64'h8000_0000_0000_0001);
      settle();

      // Capacity zero acts as one; upper data bits ignored
      write_register(tmtfc_pkg::CSR_CAPACITY, 16'hFFE0);
      send_request(64'hDEAD_BEEF_CAFE_F00D);
      settle();

      // Capacity above the row acts as the full row; threshold zero
      write_register(tmtfc_pkg::CSR_CAPACITY, 16'h001F);
      write_register(tmtfc_pkg::CSR_THRESHOLD, 16'h0000);
      send_request(64'h1);
      send_request(64'h2);
      send_request(64'h3);
      send_request(64'h1);
      settle();

      // Random phases with fresh register settings each time
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       cap = 5'd16;
            1:       cap = 5'd1;
            2:       cap = 5'd31;
            3:       cap = 5'd0;
            4:       cap = 5'd2;
            default: cap = 5'($urandom_range(0, 31));
         endcase
         case ($urandom_range(0, 7))
            0:       thr = 16'($urandom);
            1:       thr = 16'd0;
            2:       thr = 16'hFFFF;
            default: thr = 16'($urandom_range(1, 5));
         endcase
         write_register(tmtfc_pkg::CSR_CAPACITY, {11'($urandom), cap});
         write_register(tmtfc_pkg::CSR_THRESHOLD, thr);
         span = $urandom_range(2, 24);
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 63) == 0) settle();
            send_request(pick_key(span));
         end
         settle();
      end

      // Final stretch with no idling, then a capacity drop with eviction
      quiet = 1'b1;
      write_register(tmtfc_pkg::CSR_CAPACITY, 16'd16);
      write_register(tmtfc_pkg::CSR_THRESHOLD, 16'd2);
      for (int n = 0; n < 40; n++) send_request(pick_key(20));
      settle();
      write_register(tmtfc_pkg::CSR_CAPACITY, 16'd2);
      next_key = {$urandom, $urandom};
      send_request(next_key);
      send_request(~next_key);
      settle();

      if (lookups.mismatches == 0) begin
         $display("threshold_move_to_front_cache_core test passed");
      end else begin
         $display("threshold_move_to_front_cache_core test failed");
      end
      $finish;
   end

   // Abandon a hung run
   initial begin
      #40000000;
      $display("threshold_move_to_front_cache_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tmtfc_pkg.sv
rtl/tmtfc_cell.sv
rtl/threshold_move_to_front_cache_core.sv
rtl/tmtfc_checker.sv
sim/threshold_move_to_front_cache_core_tb.sv
